// ----- src/base64_mime_encoder_macros.svh -----
// Assertion macros shared by the base64 encoder checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BASE64_MIME_ENCODER_MACROS_SVH
`define BASE64_MIME_ENCODER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock, off during reset.
`define B64E_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled at the rising clock, off during reset.
`define B64E_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup of the base64 encoder.
// No dependencies.
package b64e_pkg;

  localparam logic [7:0] CharCr  = 8'd13;
  localparam logic [7:0] CharLf  = 8'd10;
  localparam logic [7:0] CharPad = 8'h3d;
  localparam logic [7:0] MinLine = 8'd4;
  localparam logic [7:0] LineLengthReset = 8'd76;
  localparam int unsigned MaxChars = 6;

  // Register index as seen in paddr bit 2.
  localparam logic RegLineLength = 1'b0;
  localparam logic RegWrapEnable = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_t;

  // Result of expanding one input byte into characters and next state.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [2:0]               count;
    logic                     last;
    logic [15:0]              held_bytes;
    logic [1:0]               held_count;
    logic [7:0]               column;
  } exp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

// ----- src/b64e_expand.sv -----
// Combinational expansion of one byte into up to six output characters.
// Depends on b64e_pkg.
module b64e_expand (
  input  b64e_pkg::in_t  item_i,
  input  logic [15:0]    held_bytes_i,
  input  logic [1:0]     held_count_i,
  input  logic [7:0]     column_i,
  input  logic [7:0]     line_length_i,
  input  logic           wrap_enable_i,
  output b64e_pkg::exp_t exp_o
);
  import b64e_pkg::*;

  logic [1:0]      n;
  logic [7:0]      b0, b1, b2;
  logic [7:0]      limit;
  logic            emit;
  logic [3:0][7:0] grp;
  logic [2:0]      k;
  logic [7:0]      col;

  always_comb begin
    n = (held_count_i == 2'd3) ? 2'd3 : held_count_i + 2'd1;
    unique case (n)
      2'd3: begin
        b0 = held_bytes_i[15:8];
        b1 = held_bytes_i[7:0];
        b2 = item_i.in_byte;
      end
      2'd2: begin
        b0 = held_bytes_i[15:8];
        b1 = item_i.in_byte;
        b2 = 8'd0;
      end
      default: begin
        b0 = item_i.in_byte;
        b1 = 8'd0;
        b2 = 8'd0;
      end
    endcase
    limit = (line_length_i < MinLine) ? MinLine : line_length_i;
    emit  = (n == 2'd3) || item_i.in_last;

    grp[0] = b64_char(b0[7:2]);
    grp[1] = b64_char({b0[1:0], b1[7:4]});
    grp[2] = (n >= 2'd2) ? b64_char({b1[3:0], b2[7:6]}) : CharPad;
    grp[3] = (n == 2'd3) ? b64_char(b2[5:0]) : CharPad;

    exp_o.chars = '0;
    k   = 3'd0;
    col = column_i;
    if (emit) begin
      for (int i = 0; i < 4; i++) begin
        exp_o.chars[k] = grp[i];
        k = k + 3'd1;
        if (wrap_enable_i) begin
          col = col + 8'd1;
          // break once the line reaches or passes its length
          if (col >= limit) begin
            exp_o.chars[k]        = CharCr;
            exp_o.chars[k + 3'd1] = CharLf;
            k   = k + 3'd2;
            col = 8'd0;
          end
        end else begin
          col = 8'd0;
        end
      end
    end
    exp_o.count = k;
    exp_o.last  = item_i.in_last;

    if (emit) begin
      exp_o.held_bytes = 16'd0;
      exp_o.held_count = 2'd0;
    end else if (n == 2'd1) begin
      exp_o.held_bytes = {item_i.in_byte, 8'd0};
      exp_o.held_count = n;
    end else begin
      exp_o.held_bytes = {held_bytes_i[15:8], item_i.in_byte};
      exp_o.held_count = n;
    end
    exp_o.column = item_i.in_last ? 8'd0 : col;
  end

endmodule

// ----- src/base64_mime_encoder.sv -----
// Streaming base64 encoder with CR LF line wrapping, top level.
// Depends on b64e_pkg and b64e_expand.
//
// Usage: message bytes enter on the in channel, one beat per byte, with
// in_last on the final byte. Characters leave on the out channel, one beat
// per character, out_last on the final character of the message.
// Each accepted byte is expanded in the same cycle into a six-entry result
// buffer: zero characters while a group of three gathers, four characters
// (plus CR LF when a line fills) when a group completes or the message ends.
// The first character of a group is offered the cycle after the byte that
// completes it. The output port gives one character per cycle while the
// receiver is ready, so a completed group holds it until all its characters
// have left; a byte that only gathers leaves the buffer empty. A new byte
// enters only as the buffer empties, so it waits for a group's last character.
// in_ready is high when the buffer is empty or its final character leaves
// in this cycle; while the receiver stalls, the buffer holds and input waits.
// Reset empties the buffer, clears held bytes and column, and loads
// line_length = 76 and wrap_enable = 1. Registers sit at byte 0 and 4.
module base64_mime_encoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  b64e_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output b64e_pkg::out_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import b64e_pkg::*;

  logic [MaxChars-1:0][7:0] chars_q, chars_d;
  logic [2:0]               cnt_q, cnt_d;
  logic                     last_q, last_d;
  logic [15:0]              held_q, held_d;
  logic [1:0]               hcnt_q, hcnt_d;
  logic [7:0]               col_q, col_d;
  logic [7:0]               line_len_q, line_len_d;
  logic                     wrap_q, wrap_d;
  logic                     in_fire, out_fire, cfg_wr;
  exp_t                     exp;

  b64e_expand u_expand (
    .item_i        (in_data_i),
    .held_bytes_i  (held_q),
    .held_count_i  (hcnt_q),
    .column_i      (col_q),
    .line_length_i (line_len_q),
    .wrap_enable_i (wrap_q),
    .exp_o         (exp)
  );

  assign out_valid_o         = (cnt_q != 3'd0);
  assign out_data_o.out_char = chars_q[0];
  assign out_data_o.out_last = last_q && (cnt_q == 3'd1);
  assign in_ready_o          = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign in_fire             = in_valid_i && in_ready_o;
  assign out_fire            = out_valid_o && out_ready_i;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegWrapEnable) ? {31'd0, wrap_q} : {24'd0, line_len_q};

  always_comb begin
    chars_d = chars_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    col_d   = col_q;
    priority if (in_fire) begin
      chars_d = exp.chars;
      cnt_d   = exp.count;
      last_d  = exp.last;
      held_d  = exp.held_bytes;
      hcnt_d  = exp.held_count;
      col_d   = exp.column;
    end else if (out_fire) begin
      // advance to the next character
      chars_d = {8'd0, chars_q[MaxChars-1:1]};
      cnt_d   = cnt_q - 3'd1;
    end else begin
      // hold
      cnt_d   = cnt_q;
    end
  end

  always_comb begin
    line_len_d = line_len_q;
    wrap_d     = wrap_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        RegLineLength: line_len_d = pwdata[7:0];
        RegWrapEnable: wrap_d     = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= 3'd0;
      last_q     <= 1'b0;
      held_q     <= 16'd0;
      hcnt_q     <= 2'd0;
      col_q      <= 8'd0;
      line_len_q <= LineLengthReset;
      wrap_q     <= 1'b1;
    end else begin
      cnt_q      <= cnt_d;
      last_q     <= last_d;
      held_q     <= held_d;
      hcnt_q     <= hcnt_d;
      col_q      <= col_d;
      line_len_q <= line_len_d;
      wrap_q     <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

// ----- src/b64e_checker.sv -----
// Port-level assertions for base64_mime_encoder, attached by bind.
// Depends on b64e_pkg and base64_mime_encoder_macros.svh.
`include "base64_mime_encoder_macros.svh"

module b64e_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input b64e_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input b64e_pkg::out_t out_data_o
);
  import b64e_pkg::*;

  // a stalled beat holds
  `B64E_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // no new byte while a stalled character waits
  `B64E_ASSERT_NOW(a_stall_blocks_in, out_valid_o && !out_ready_i, !in_ready_o)

  // CR is always followed directly by LF
  `B64E_ASSERT_NEXT(a_cr_lf, out_valid_o && out_ready_i && out_data_o.out_char == CharCr, out_valid_o && out_data_o.out_char == CharLf)

  // nothing follows the final character unless a new byte came in
  `B64E_ASSERT_NEXT(a_idle_after_last, out_valid_o && out_ready_i && out_data_o.out_last && !(in_valid_i && in_ready_o), !out_valid_o)

endmodule

bind base64_mime_encoder b64e_checker u_checker (.*);

// ----- sim/tb_base64_mime_encoder.sv -----
// Self-checking testbench for base64_mime_encoder: directed messages, then random message streams.
// A scoreboard class predicts every character and every CR LF break, and checks each output beat.
// Depends on b64e_pkg and the encoder RTL only.
module tb_base64_mime_encoder;
  import b64e_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned BytesPerPhase = 26;

  class encoder_scoreboard;
    logic [7:0]  line_len;
    logic        wrap_en;
    logic [15:0] held;
    logic [1:0]  held_n;
    logic [7:0]  column;
    out_t        pending_chars[$];
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned chars_checked;

    function new();
      line_len = LineLengthReset;
      wrap_en = 1'b1;
      held = '0;
      held_n = '0;
      column = '0;
      errors = 0;
      bytes_in = 0;
      chars_checked = 0;
    endfunction

    function void set_reg(logic sel, logic [31:0] v);
      case (sel)
        RegLineLength: line_len = v[7:0];
        RegWrapEnable: wrap_en = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction

    // Append one expected beat at the tail.
    function void queue_beat(out_t o);
      pending_chars.insert(pending_chars.size(), o);
    endfunction

    function void push_char(logic [7:0] c);
      logic [7:0] limit;
      out_t       o;
      limit = (line_len < MinLine) ? MinLine : line_len;
      o.out_char = c;
      o.out_last = 1'b0;
      queue_beat(o);
      if (wrap_en) begin
        column = column + 8'd1;
        if (column >= limit) begin
          o.out_char = CharCr;
          queue_beat(o);
          o.out_char = CharLf;
          queue_beat(o);
          column = '0;
        end
      end else begin
        column = '0;
      end
    endfunction

    function void push_sextet(logic [5:0] v);
      logic [0:63][7:0] alpha;
      alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      push_char(alpha[v]);
    endfunction

    // Predict the characters one accepted byte releases.
    function void encode_byte(in_t item);
      logic [7:0] b0, b1, b2;
      logic [1:0] n;
      int         start;
      out_t       tail;
      start = pending_chars.size();
      n = held_n + 2'd1;
      b0 = item.in_byte;
      b1 = '0;
      b2 = '0;
      if (n == 2'd3) begin
        b0 = held[15:8];
        b1 = held[7:0];
        b2 = item.in_byte;
      end else if (n == 2'd2) begin
        b0 = held[15:8];
        b1 = item.in_byte;
      end
      if (n == 2'd3 || item.in_last) begin
        push_sextet(b0[7:2]);
        push_sextet({b0[1:0], b1[7:4]});
        if (n >= 2'd2) push_sextet({b1[3:0], b2[7:6]});
        else push_char(CharPad);
        if (n == 2'd3) push_sextet(b2[5:0]);
        else push_char(CharPad);
        held = '0;
        held_n = '0;
      end else begin
        if (n == 2'd1) held = {item.in_byte, 8'h00};
        else held[7:0] = item.in_byte;
        held_n = n;
      end
      if (item.in_last) begin
        if (pending_chars.size() > start) begin
          tail = pending_chars.pop_back();
          tail.out_last = 1'b1;
          queue_beat(tail);
        end
        held = '0;
        held_n = '0;
        column = '0;
      end
      bytes_in++;
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t: mismatch on %s: got %02h, want %02h", $time, what, got, want);
      errors++;
    endtask

    task check_char(out_t got);
      out_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected beat", got.out_char, 8'h00);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (got.out_char !== want.out_char)
          report_mismatch("out_char", got.out_char, want.out_char);
        if (got.out_last !== want.out_last)
          report_mismatch("out_last", {7'd0, got.out_last}, {7'd0, want.out_last});
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  encoder_scoreboard sb = new();
  bit                steady = 1'b0;
  int unsigned       cycle_count = 0;
  int unsigned       settings_used = 0;

  base64_mime_encoder uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stall about 12 beats in a hundred unless in a steady stretch.
  always @(negedge clk_i) begin
    out_ready_i = steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_char(out_data_o);
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    in_t item;
    item.in_byte = b;
    item.in_last = l;
    if (!steady && $urandom_range(99) < 12) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.encode_byte(item);
  endtask

  // Drop valid and hold off until every predicted character has left.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(sel, v);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(input logic [7:0] len, input logic wrap);
    wait_idle();
    write_reg(RegLineLength, {24'd0, len});
    write_reg(RegWrapEnable, {31'd0, wrap});
    settings_used++;
  endtask

  initial begin
    int unsigned msg_left;
    logic [7:0]  len;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: one-, two- and three-byte messages at the byte extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'haa, 1'b1);

    // Line length below the minimum: a full group and a padded tail each end a line.
    configure(8'd0, 1'b1);
    send_byte(8'hfc, 1'b0);
    send_byte(8'h0f, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h5a, 1'b1);

    // Shorten the line while twelve characters already sit on it.
    configure(8'd76, 1'b1);
    for (int i = 1; i <= 9; i++) send_byte(8'(8'h11 * i), 1'b0);
    configure(8'd5, 1'b1);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h81, 1'b1);

    // Wrapping off.
    configure(8'd4, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);

    // Random streams; messages run across setting changes.
    msg_left = 0;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: len = 8'd4;
        1: len = 8'd255;
        3: len = 8'($urandom_range(3));
        5: len = 8'd76;
        default: len = 8'($urandom_range(4, 40));
      endcase
      configure(len, ph != 2);
      steady = (ph == 1);
      for (int i = 0; i < BytesPerPhase; i++) begin
        if (msg_left == 0)
          msg_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        msg_left--;
        send_byte(8'($urandom_range(255)), msg_left == 0);
      end
      steady = 1'b0;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Encoded %0d bytes into %0d checked characters across %0d register settings,",
             sb.bytes_in, sb.chars_checked, settings_used + 1);
    $display("line lengths from below the minimum up to 255, with wrapping on and off.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
